>>> hw/rtl/qmpm_pkg.sv
// ----------------------------------------------------------------------------
// qmpm_pkg
// Types, codes and helper functions shared by the four-motor PWM mixer.
// ----------------------------------------------------------------------------
package qmpm_pkg;

	localparam int NumMotors = 4;

	// Item kinds carried on the cmd field.
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_KEY    = 2'd1;
	localparam logic [1:0] CMD_SERIAL = 2'd2;

	// Motion commands, shared by the key codes and serial bytes one to six.
	localparam logic [2:0] MOV_NONE       = 3'd0;
	localparam logic [2:0] MOV_ALL_UP     = 3'd1;
	localparam logic [2:0] MOV_ALL_DOWN   = 3'd2;
	localparam logic [2:0] MOV_PAIR_B_UP  = 3'd3;
	localparam logic [2:0] MOV_PAIR_B_DN  = 3'd4;
	localparam logic [2:0] MOV_PAIR_A_DN  = 3'd5;
	localparam logic [2:0] MOV_PAIR_A_UP  = 3'd6;

	// Serial link control bytes.
	localparam logic [7:0] TAKE_BYTE    = 8'h55;
	localparam logic [7:0] RELEASE_BYTE = 8'h66;

	// Direction pin patterns after an all-up and an all-down command.
	localparam logic [7:0] UP_PATTERN   = 8'h69;
	localparam logic [7:0] DOWN_PATTERN = 8'h00;

	// Notice codes.
	localparam logic [1:0] NOTICE_NONE     = 2'd0;
	localparam logic [1:0] NOTICE_TAKEN    = 2'd1;
	localparam logic [1:0] NOTICE_RELEASED = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic CFG_DUTY_STEP  = 1'b0;
	localparam logic CFG_PERIOD_TOP = 1'b1;
	localparam logic [6:0] DUTY_STEP_RESET  = 7'd15;
	localparam logic [7:0] PERIOD_TOP_RESET = 8'd100;

	// Per-duty adjustment codes.
	localparam logic [1:0] ADJ_HOLD = 2'd0;
	localparam logic [1:0] ADJ_UP   = 2'd1;
	localparam logic [1:0] ADJ_DOWN = 2'd2;

	typedef logic [7:0] duty_t;
	typedef logic [1:0] adj_t;

	// Move one duty by the step in the given direction, then clamp to 0..top.
	function automatic duty_t adjust_duty(input duty_t duty, input logic [6:0] step,
	                                      input logic [7:0] top, input adj_t adj);
		logic [8:0] sum;
		logic [8:0] val;
		begin
			sum = {1'b0, duty} + {2'b00, step};
			unique case (adj)
				ADJ_UP:   val = sum;
				ADJ_DOWN: val = (duty < {1'b0, step}) ? 9'd0
				                : {1'b0, duty} - {2'b00, step};
				default:  val = {1'b0, duty};
			endcase
			adjust_duty = (val > {1'b0, top}) ? top : val[7:0];
		end
	endfunction

endpackage

>>> hw/rtl/qmpm_item_if.sv
// ----------------------------------------------------------------------------
// qmpm_item_if
// Input channel of the mixer: one tick, key command or serial byte per word.
// ----------------------------------------------------------------------------
interface qmpm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [2:0] key_code;
	logic [7:0] serial_byte;

	modport source (output valid, output cmd, output key_code, output serial_byte,
	                input ready);
	modport sink (input valid, input cmd, input key_code, input serial_byte,
	              output ready);
endinterface

>>> hw/rtl/qmpm_result_if.sv
// ----------------------------------------------------------------------------
// qmpm_result_if
// Output channel of the mixer: pulse levels, authority, direction and notice.
// ----------------------------------------------------------------------------
interface qmpm_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] pulse_bits;
	logic       remote_mode;
	logic [7:0] motor_direction;
	logic [1:0] notice;

	modport source (output valid, output pulse_bits, output remote_mode,
	                output motor_direction, output notice, input ready);
	modport sink (input valid, input pulse_bits, input remote_mode,
	              input motor_direction, input notice, output ready);
endinterface

>>> hw/rtl/quad_motor_pwm_mixer_top.sv
// ----------------------------------------------------------------------------
// quad_motor_pwm_mixer_top
// Four-motor PWM generator with throttle and attitude mixing.
// ----------------------------------------------------------------------------
// Results are registered; the output register is refilled in the cycle it is taken.
// Throughput: one word per cycle, stalling while a full result is not taken.
// The single state update (one add, clamp and compare per motor) sets that rate.
// Reset (arst_n low, asynchronous) clears all duties, the counter, authority and
// direction, sets all four pulses high, and loads duty_step 15 and period_top 100.
// ----------------------------------------------------------------------------
module quad_motor_pwm_mixer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	qmpm_item_if.sink   item,
	qmpm_result_if.source result
);
	import qmpm_pkg::*;

	// Configuration registers.
	logic [6:0] duty_step_q;
	logic [7:0] period_top_q;

	// Block state.
	logic [7:0] tick_count_q;
	duty_t      duty_q [NumMotors];
	logic       auth_q;
	logic [7:0] dir_q;
	logic [3:0] pulse_q;

	// Output register.
	logic       out_valid_q;
	logic [3:0] out_pulse_q;
	logic       out_remote_q;
	logic [7:0] out_dir_q;
	logic [1:0] out_notice_q;

	// Next-state values for the word being accepted.
	logic [7:0] tick_next;
	logic [8:0] tick_inc;
	duty_t      duty_next [NumMotors];
	logic [3:0] pulse_next;
	logic       auth_next;
	logic [7:0] dir_next;
	logic [1:0] notice_next;
	logic       apply_move;
	logic [2:0] move_code;
	adj_t       adj [NumMotors];
	logic       accept;

	// A new word enters whenever the output register is empty or is being
	// emptied in this cycle, so the block runs at one word per clock.
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// Configuration writes land directly in their registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q  <= DUTY_STEP_RESET;
			period_top_q <= PERIOD_TOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DUTY_STEP:  duty_step_q  <= cfg_wdata[6:0];
				CFG_PERIOD_TOP: period_top_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decode which motion command applies. Key commands act only without
	// remote authority, serial commands one to six only with it. Any applied
	// key code, even one that names no motion, still clamps all duties.
	always_comb begin
		apply_move  = 1'b0;
		move_code   = MOV_NONE;
		auth_next   = auth_q;
		notice_next = NOTICE_NONE;
		unique case (item.cmd)
			CMD_KEY: begin
				apply_move = !auth_q;
				move_code  = item.key_code;
			end
			CMD_SERIAL: begin
				priority if (item.serial_byte == TAKE_BYTE) begin
					auth_next   = 1'b1;
					notice_next = NOTICE_TAKEN;
				end else if (item.serial_byte == RELEASE_BYTE) begin
					if (auth_q) begin
						auth_next   = 1'b0;
						notice_next = NOTICE_RELEASED;
					end
				end else if (item.serial_byte[7:3] == 5'd0 &&
				             item.serial_byte[2:0] != MOV_NONE &&
				             item.serial_byte[2:0] != 3'd7) begin
					apply_move = auth_q;
					move_code  = item.serial_byte[2:0];
				end
			end
			default: ;
		endcase
	end

	// Per-motor adjustment for the decoded command.
	always_comb begin
		for (int i = 0; i < NumMotors; i++) begin
			adj[i] = ADJ_HOLD;
		end
		dir_next = dir_q;
		if (apply_move) begin
			unique case (move_code)
				MOV_ALL_UP: begin
					for (int i = 0; i < NumMotors; i++) begin
						adj[i] = ADJ_UP;
					end
					dir_next = UP_PATTERN;
				end
				MOV_ALL_DOWN: begin
					for (int i = 0; i < NumMotors; i++) begin
						adj[i] = ADJ_DOWN;
					end
					dir_next = DOWN_PATTERN;
				end
				MOV_PAIR_B_UP: begin
					adj[1] = ADJ_UP;
					adj[2] = ADJ_DOWN;
				end
				MOV_PAIR_B_DN: begin
					adj[1] = ADJ_DOWN;
					adj[2] = ADJ_UP;
				end
				MOV_PAIR_A_DN: begin
					adj[0] = ADJ_DOWN;
					adj[3] = ADJ_UP;
				end
				MOV_PAIR_A_UP: begin
					adj[0] = ADJ_UP;
					adj[3] = ADJ_DOWN;
				end
				default: ;
			endcase
		end
	end

	// Duties are moved and clamped on an applied command, and only clamped on
	// a tick. The counter wraps to zero once it would pass period_top; the
	// pulse of a motor is high while the new count does not exceed its duty.
	always_comb begin
		tick_inc  = {1'b0, tick_count_q} + 9'd1;
		tick_next = tick_count_q;
		pulse_next = pulse_q;
		for (int i = 0; i < NumMotors; i++) begin
			duty_next[i] = duty_q[i];
		end
		if (item.cmd == CMD_TICK) begin
			tick_next = (tick_inc > {1'b0, period_top_q}) ? 8'd0 : tick_inc[7:0];
			for (int i = 0; i < NumMotors; i++) begin
				duty_next[i]  = adjust_duty(duty_q[i], duty_step_q, period_top_q, ADJ_HOLD);
				pulse_next[i] = (tick_next <= duty_next[i]);
			end
		end else if (apply_move) begin
			for (int i = 0; i < NumMotors; i++) begin
				duty_next[i] = adjust_duty(duty_q[i], duty_step_q, period_top_q, adj[i]);
			end
		end
	end

	// State registers advance only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= 8'd0;
			auth_q       <= 1'b0;
			dir_q        <= 8'd0;
			pulse_q      <= 4'hF;
			for (int i = 0; i < NumMotors; i++) begin
				duty_q[i] <= '0;
			end
		end else if (accept) begin
			tick_count_q <= tick_next;
			auth_q       <= auth_next;
			dir_q        <= dir_next;
			pulse_q      <= pulse_next;
			for (int i = 0; i < NumMotors; i++) begin
				duty_q[i] <= duty_next[i];
			end
		end
	end

	// Output register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_pulse_q  <= pulse_next;
			out_remote_q <= auth_next;
			out_dir_q    <= dir_next;
			out_notice_q <= notice_next;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.pulse_bits      = out_pulse_q;
	assign result.remote_mode     = out_remote_q;
	assign result.motor_direction = out_dir_q;
	assign result.notice          = out_notice_q;

endmodule
